// ===== hw/rtl/ffba_pkg.sv =====
// Shared constants and types for the first-fit block allocator.
package ffba_pkg;

	// Default number of blocks in the allocation table.
	localparam int TABLE_DEPTH_DEF = 1024;

	// Block size in bytes (a power of two) and its shift and low-bit mask.
	localparam int BLOCK_BYTES = 4096;
	localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
	localparam logic [31:0] BLOCK_MASK = 32'(BLOCK_BYTES - 1);

	// Width of a request rounded up to whole blocks.
	localparam int BLOCKS_W = 33 - BLOCK_SHIFT;

	// Configuration register indexes.
	localparam logic [1:0] CFG_HEAP_BASE     = 2'd0;
	localparam logic [1:0] CFG_BLOCKS_IN_USE = 2'd1;

	// Table entry flags.
	localparam logic [2:0] ENT_FREE  = 3'b000;
	localparam logic [2:0] ENT_TAKEN = 3'b001;
	localparam logic [2:0] ENT_FIRST = 3'b010;
	localparam logic [2:0] ENT_NEXT  = 3'b100;

	// Status reported by the allocation engine.
	typedef struct packed {
		logic clearing;
		logic busy;
	} back_status_t;

endpackage

// ===== hw/rtl/ffba_front.sv =====
// Request front end: rounds the byte count to blocks and flags requests that cannot fit.
module ffba_front #(
	parameter int TABLE_DEPTH = ffba_pkg::TABLE_DEPTH_DEF,
	parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [31:0]           request_bytes,
	input  logic [10:0]           blocks_in_use,
	input  ffba_pkg::back_status_t status,
	input  logic                  q_full,
	output logic                  q_push,
	output logic [2*CW:0]         q_data
);
	import ffba_pkg::*;

	logic [32:0]         bytes_up;
	logic [BLOCKS_W-1:0] blocks;
	logic [CW-1:0]       limit;
	logic                refuse;

	// Round the request up to a whole number of blocks.
	assign bytes_up = {1'b0, request_bytes} + 33'(BLOCK_BYTES - 1);
	assign blocks   = bytes_up[32:BLOCK_SHIFT];

	// The scan count saturates at the table depth.
	assign limit = (32'(blocks_in_use) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
		: CW'(blocks_in_use);

	// A zero-size request or one longer than the scanned range is refused at once.
	assign refuse = (blocks == '0) || (32'(blocks) > 32'(limit));

	// Items wait in the queue; none are taken during the table clear.
	assign in_ready = !q_full && !status.clearing;
	assign q_push   = in_valid && in_ready;
	assign q_data   = {refuse, CW'(blocks), limit};

endmodule

// ===== hw/rtl/ffba_queue.sv =====
// Two-entry queue between the request front end and the allocation engine.
module ffba_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         full,
	output logic         empty
);

	logic [W-1:0] slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Storage slots.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/ffba_back.sv =====
// Allocation engine: clears the table, scans it for a free run, marks the run and returns the result.
module ffba_back #(
	parameter int TABLE_DEPTH = ffba_pkg::TABLE_DEPTH_DEF,
	parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	input  logic [2*CW:0]          q_data,
	output logic                   q_pop,
	input  logic [31:0]            heap_base,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   granted,
	output logic [31:0]            block_address,
	output ffba_pkg::back_status_t status
);
	import ffba_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_MARK
	} state_t;

	state_t        state_q;
	logic [2:0]    table_mem [TABLE_DEPTH];
	logic [2:0]    rd_data_s1;
	logic [CW-1:0] addr_s1;
	logic          pend_s1;
	logic [CW-1:0] issue_idx_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] limit_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] start_q;
	logic [CW-1:0] mark_idx_q;
	logic [CW-1:0] left_q;
	logic          first_q;
	logic          out_valid_q;
	logic          granted_q;
	logic [31:0]   addr_q;

	logic          q_refuse;
	logic [CW-1:0] q_len;
	logic [CW-1:0] q_limit;
	logic [CW-1:0] count_nx;
	logic [CW-1:0] run_start;
	logic          entry_taken;
	logic          mem_we;
	logic [CW-1:0] mem_waddr;
	logic [2:0]    mem_wdata;

	assign {q_refuse, q_len, q_limit} = q_data;

	// Take a new item only when the result slot is empty.
	assign q_pop = (state_q == ST_IDLE) && !q_empty && !out_valid_q;

	// Run tracking for the entry whose read data is arriving.
	assign entry_taken = (rd_data_s1 & ENT_TAKEN) != ENT_FREE;
	assign count_nx    = count_q + CW'(1);
	assign run_start   = (count_q == '0) ? addr_s1 : start_q;

	// Table write port: the clearing sweep or the run marking.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = mark_idx_q;
		mem_wdata = ENT_FREE;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_MARK: begin
				mem_we    = 1'b1;
				mem_wdata = ENT_TAKEN | (first_q ? ENT_FIRST : ENT_FREE)
					| ((left_q > CW'(1)) ? ENT_NEXT : ENT_FREE);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Table memory with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[mem_waddr[AW-1:0]] <= mem_wdata;
		end
		rd_data_s1 <= table_mem[issue_idx_q[AW-1:0]];
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			mark_idx_q  <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			issue_idx_q <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					mark_idx_q <= mark_idx_q + CW'(1);
					if (mark_idx_q == CW'(TABLE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						len_q       <= q_len;
						limit_q     <= q_limit;
						issue_idx_q <= '0;
						count_q     <= '0;
						pend_s1     <= 1'b0;
						if (q_refuse) begin
							out_valid_q <= 1'b1;
							granted_q   <= 1'b0;
							addr_q      <= '0;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// Issue the next read while the previous entry is checked.
					if (issue_idx_q < limit_q) begin
						issue_idx_q <= issue_idx_q + CW'(1);
						addr_s1     <= issue_idx_q;
						pend_s1     <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
					end
					if (pend_s1) begin
						if (entry_taken) begin
							count_q <= '0;
						end else begin
							count_q <= count_nx;
							start_q <= run_start;
							if (count_nx == len_q) begin
								mark_idx_q <= run_start;
								left_q     <= len_q;
								first_q    <= 1'b1;
								state_q    <= ST_MARK;
							end
						end
					end else if (issue_idx_q >= limit_q) begin
						out_valid_q <= 1'b1;
						granted_q   <= 1'b0;
						addr_q      <= '0;
						state_q     <= ST_IDLE;
					end
				end
				ST_MARK: begin
					mark_idx_q <= mark_idx_q + CW'(1);
					left_q     <= left_q - CW'(1);
					first_q    <= 1'b0;
					if (left_q == CW'(1)) begin
						out_valid_q <= 1'b1;
						granted_q   <= 1'b1;
						addr_q      <= (heap_base & ~BLOCK_MASK)
							+ (32'(start_q) << BLOCK_SHIFT);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign granted         = granted_q;
	assign block_address   = addr_q;
	assign status.clearing = (state_q == ST_CLEAR);
	assign status.busy     = (state_q == ST_SCAN) || (state_q == ST_MARK);

endmodule

// ===== hw/rtl/first_fit_block_allocator_core.sv =====
// Top level of the first-fit block allocator.
//
//  Port group   Direction  Handshake             Payload
//  in           input      in_valid/in_ready     request_bytes
//  out          output     out_valid/out_ready   granted, block_address
//  cfg          input      cfg_wr_en             cfg_index, cfg_wdata
//
// After reset the table is swept to free, one entry per cycle, over all TABLE_DEPTH entries;
// no item is accepted during that sweep.
// A granted item is first scanned and then marked between acceptance and result:
// the table memory is read one entry a cycle and then written one entry a cycle.
// Items refused up front skip the scan and are answered from idle; a failed scan answers once its range is read.
// Two items wait in the queue while one is served; a result holds the engine until taken.
module first_fit_block_allocator_core #(
	parameter int TABLE_DEPTH = ffba_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] request_bytes,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        granted,
	output logic [31:0] block_address,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	import ffba_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [31:0]   heap_base_q;
	logic [10:0]   blocks_in_use_q;
	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_empty;
	logic [2*CW:0] q_wdata;
	logic [2*CW:0] q_rdata;
	back_status_t  status;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q     <= '0;
			blocks_in_use_q <= 11'd1024;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_HEAP_BASE: begin
					heap_base_q <= cfg_wdata;
				end
				CFG_BLOCKS_IN_USE: begin
					blocks_in_use_q <= cfg_wdata[10:0];
				end
				default: begin
					heap_base_q <= heap_base_q;
				end
			endcase
		end
	end

	ffba_front #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.CW(CW)
	) u_front (
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.request_bytes (request_bytes),
		.blocks_in_use (blocks_in_use_q),
		.status        (status),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_data        (q_wdata)
	);

	ffba_queue #(
		.W(2 * CW + 1)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.full      (q_full),
		.empty     (q_empty)
	);

	ffba_back #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.CW(CW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_data        (q_rdata),
		.q_pop         (q_pop),
		.heap_base     (heap_base_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.granted       (granted),
		.block_address (block_address),
		.status        (status)
	);

`ifndef SYNTHESIS
	// A refused item always reports address zero.
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !granted) |-> (block_address == 32'd0))
		else $error("refused item with nonzero address");

	// A granted address is block aligned.
	a_granted_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && granted) |-> ((block_address & BLOCK_MASK) == 32'd0))
		else $error("granted address not block aligned");

	// No item enters while the table is being cleared.
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		status.clearing |-> !in_ready)
		else $error("item accepted during table clear");

	// The engine never starts an item while a result is still waiting.
	a_pop_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !(status.busy && $past(out_valid)))
		else $error("item started with result slot occupied");
`endif

endmodule
